// ===== src/route_table_longest_prefix_defines.svh =====
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared assertion forms for the longest-prefix route table.
// ----------------------------------------------------------------------------
`ifndef ROUTE_TABLE_LONGEST_PREFIX_DEFINES_SVH
`define ROUTE_TABLE_LONGEST_PREFIX_DEFINES_SVH

// Check a property on every rising edge outside of reset.
`define RTLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RTLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rtlp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtlp_pkg
// Widths, codes and types shared by the route table modules.
// ----------------------------------------------------------------------------
package rtlp_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int ADDR_W   = 32;
  localparam int MAC_W    = 48;
  localparam int PORT_W   = 8;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int SCORE_W  = 6;

  // Operation codes on func
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] mask;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  typedef struct packed {
    logic               dup;
    logic               match;
    logic [SCORE_W-1:0] score;
  } score_t;

endpackage

// ===== src/rtlp_ram.sv =====
// ----------------------------------------------------------------------------
// rtlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/rtlp_score.sv =====
// ----------------------------------------------------------------------------
// rtlp_score
// Shared compare unit: scores one stored route against the held item.
// ----------------------------------------------------------------------------
module rtlp_score (
  input  logic [rtlp_pkg::ADDR_W-1:0] key_addr,
  input  logic [rtlp_pkg::ADDR_W-1:0] key_mask,
  input  rtlp_pkg::route_t            route,
  output rtlp_pkg::score_t            result
);

  import rtlp_pkg::*;

  // Leading ones from bit 31, as a five-level shift search.
  function automatic logic [SCORE_W-1:0] lead_ones(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0]  x;
    logic [SCORE_W-1:0] n;
    x = v;
    n = '0;
    if (&x[31:16]) begin
      n = n + SCORE_W'(16);
      x = x << 16;
    end
    if (&x[31:24]) begin
      n = n + SCORE_W'(8);
      x = x << 8;
    end
    if (&x[31:28]) begin
      n = n + SCORE_W'(4);
      x = x << 4;
    end
    if (&x[31:30]) begin
      n = n + SCORE_W'(2);
      x = x << 2;
    end
    if (x[31]) begin
      n = n + SCORE_W'(1);
      x = x << 1;
    end
    if (x[31]) begin
      n = n + SCORE_W'(1);
    end
    return n;
  endfunction

  logic [SCORE_W-1:0] score;
  logic [SCORE_W-1:0] need;

  assign score = lead_ones(~(route.dst ^ key_addr));
  assign need  = lead_ones(route.mask);

  assign result.dup   = (route.dst == key_addr) && (route.mask == key_mask);
  assign result.match = (score >= need);
  assign result.score = score;

endmodule

// ===== src/route_table_longest_prefix.sv =====
// ----------------------------------------------------------------------------
// route_table_longest_prefix
// IPv4 route table with insert and longest-prefix lookup.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries func, addr, mask, gw_mac
// and port. func selects insert or lookup. Each transaction gives exactly one
// result transaction (out_valid/out_ready) with status, entry_index, hop_mac
// and out_port.
// The block works on one item at a time: in_ready is high only while idle.
// Both operations scan the stored routes through one RAM read port and one
// compare unit, one route per cycle. When the scan is through, the result is
// registered onto the output, and the next item is taken only after the
// receiver has accepted that result.
// An accepted insert is written to the RAM as the result is produced.
// While the receiver stalls, the result is held and no new item is taken.
// Reset empties the table (route count to zero) and drops any result in
// flight; route storage itself is not cleared.
// ----------------------------------------------------------------------------
`include "route_table_longest_prefix_defines.svh"

module route_table_longest_prefix #(
  parameter int ENTRIES = rtlp_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [rtlp_pkg::ADDR_W-1:0]   addr,
  input  logic [rtlp_pkg::ADDR_W-1:0]   mask,
  input  logic [rtlp_pkg::MAC_W-1:0]    gw_mac,
  input  logic [rtlp_pkg::PORT_W-1:0]   port,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtlp_pkg::STATUS_W-1:0] status,
  output logic [rtlp_pkg::IDX_W-1:0]    entry_index,
  output logic [rtlp_pkg::MAC_W-1:0]    hop_mac,
  output logic [rtlp_pkg::PORT_W-1:0]   out_port
);

  import rtlp_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [CW-1:0]      route_count;
  logic [CW-1:0]      scan_idx;
  logic               pend;
  logic [IW-1:0]      pend_idx;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [SCORE_W-1:0] best_score;
  logic [MAC_W-1:0]   best_mac;
  logic [PORT_W-1:0]  best_port;

  logic               q_func;
  logic [ADDR_W-1:0]  q_addr;
  logic [ADDR_W-1:0]  q_mask;
  logic [MAC_W-1:0]   q_mac;
  logic [PORT_W-1:0]  q_port;

  logic               in_fire;
  logic               issue;
  logic               finish;
  logic               full;
  logic               wr_en;
  route_t             wr_route;
  route_t             rd_route;
  logic [ROUTE_W-1:0] rd_data;
  score_t             sc;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state == S_SCAN) && (scan_idx < route_count);
  assign finish   = (state == S_SCAN) && !issue && !pend;
  assign full     = (route_count == CW'(ENTRIES));
  assign wr_en    = finish && (q_func == FN_INSERT) && !found && !full;

  assign wr_route.dst  = q_addr;
  assign wr_route.mask = q_mask;
  assign wr_route.mac  = q_mac;
  assign wr_route.port = q_port;
  assign rd_route      = route_t'(rd_data);

  rtlp_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (route_count[IW-1:0]),
    .wr_data (ROUTE_W'(wr_route)),
    .rd_en   (issue),
    .rd_addr (scan_idx[IW-1:0]),
    .rd_data (rd_data)
  );

  rtlp_score u_score (
    .key_addr (q_addr),
    .key_mask (q_mask),
    .route    (rd_route),
    .result   (sc)
  );

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route_count <= '0;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      found       <= 1'b0;
      scan_idx    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state    <= S_SCAN;
            scan_idx <= '0;
            pend     <= 1'b0;
            found    <= 1'b0;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (pend) begin
            if (q_func == FN_INSERT) begin
              if (sc.dup) begin
                found <= 1'b1;
              end
            end else if (sc.match && (!found || sc.score > best_score)) begin
              found <= 1'b1;
            end
          end
          if (finish) begin
            state     <= S_DONE;
            out_valid <= 1'b1;
            if (wr_en) begin
              route_count <= route_count + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item hold, best-route tracking and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_func     <= func;
      q_addr     <= addr;
      q_mask     <= mask;
      q_mac      <= gw_mac;
      q_port     <= port;
      best_score <= '0;
    end
    if ((state == S_SCAN) && issue) begin
      pend_idx <= scan_idx[IW-1:0];
    end
    if ((state == S_SCAN) && pend) begin
      if (q_func == FN_INSERT) begin
        // keep the first duplicate only
        if (sc.dup && !found) begin
          best_idx <= pend_idx;
        end
      end else if (sc.match && (!found || sc.score > best_score)) begin
        best_idx   <= pend_idx;
        best_score <= sc.score;
        best_mac   <= rd_route.mac;
        best_port  <= rd_route.port;
      end
    end
    if (finish) begin
      hop_mac  <= '0;
      out_port <= '0;
      if (q_func == FN_INSERT) begin
        if (found) begin
          status      <= ST_DUP;
          entry_index <= IDX_W'(best_idx);
        end else if (full) begin
          status      <= ST_FULL;
          entry_index <= '0;
        end else begin
          status      <= ST_OK;
          entry_index <= IDX_W'(route_count);
        end
      end else if (found) begin
        status      <= ST_OK;
        entry_index <= IDX_W'(best_idx);
        hop_mac     <= best_mac;
        out_port    <= best_port;
      end else begin
        status      <= ST_MISS;
        entry_index <= '0;
      end
    end
  end

  `RTLP_ASSERT(a_one_item, clk, rst, !(in_ready && out_valid), "input taken while result pending")
  `RTLP_ASSERT(a_count_max, clk, rst, route_count <= CW'(ENTRIES), "route count above table size")
  `RTLP_ASSERT(a_count_inc, clk, rst, wr_en |=> route_count == $past(route_count) + 1'b1, "route count did not advance on insert")
  `RTLP_ASSERT(a_full_status, clk, rst, (out_valid && status == ST_FULL) |-> full, "table full reported below capacity")

endmodule
